/* src/asp_pkg.sv */
// ----------------------------------------------------------------------------
// asp_pkg
// shared constants and tables of the spiral point generator
// ----------------------------------------------------------------------------
package asp_pkg;

    localparam int IDX_WIDTH    = 13;
    localparam int CORDIC_STEPS = 30;
    localparam int REG_ADDR_W   = 2;

    localparam logic [REG_ADDR_W-1:0] REG_OFFSET_A    = 2'd0;
    localparam logic [REG_ADDR_W-1:0] REG_GROWTH_B    = 2'd1;
    localparam logic [REG_ADDR_W-1:0] REG_POINT_COUNT = 2'd2;

    localparam logic [IDX_WIDTH-1:0] COUNT_RESET = 13'd100;

    localparam logic [29:0] TEN_PI_Q24        = 30'd527071785;
    localparam logic [27:0] TWO_PI_Q24        = 28'd105414357;
    localparam logic [27:0] PI_Q24            = 28'd52707179;
    localparam logic [27:0] HALF_PI_Q24       = 28'd26353589;
    localparam logic [27:0] THREE_HALF_PI_Q24 = 28'd79060768;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // angles are held below 2^30 in q.24 (theta <= 10 pi)
    localparam int ANG_W  = 30;
    // cordic datapath width in q2.30 plus headroom
    localparam int CD_W   = 34;

    function automatic logic signed [CD_W-1:0] atan_q30(input int i);
        logic signed [CD_W-1:0] v;
        case (i)
            0: v = 34'sd843314856;   1: v = 34'sd497837829;
            2: v = 34'sd263043836;   3: v = 34'sd133525158;
            4: v = 34'sd67021686;    5: v = 34'sd33543515;
            6: v = 34'sd16775850;    7: v = 34'sd8388437;
            8: v = 34'sd4194282;     9: v = 34'sd2097149;
            10: v = 34'sd1048575;    11: v = 34'sd524287;
            12: v = 34'sd262143;     13: v = 34'sd131071;
            14: v = 34'sd65535;      15: v = 34'sd32767;
            16: v = 34'sd16383;      17: v = 34'sd8191;
            18: v = 34'sd4095;       19: v = 34'sd2047;
            20: v = 34'sd1023;       21: v = 34'sd511;
            22: v = 34'sd255;        23: v = 34'sd127;
            24: v = 34'sd63;         25: v = 34'sd31;
            26: v = 34'sd15;         27: v = 34'sd8;
            28: v = 34'sd4;          29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* src/asp_div_cell.sv */
// ----------------------------------------------------------------------------
// asp_div_cell
// one restoring division step producing one quotient bit per cycle while en is high
// ----------------------------------------------------------------------------
module asp_div_cell #(
    parameter int NW  = 13,
    parameter int QW  = 31,
    parameter int PW  = 128
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW:0]   rem_in,
    input  logic [NW-1:0] den_in,
    input  logic          num_bit,
    input  logic [QW-1:0] quo_in,
    input  logic [PW-1:0] pass_in,
    output logic [NW:0]   rem_out,
    output logic [NW-1:0] den_out,
    output logic [QW-1:0] quo_out,
    output logic [PW-1:0] pass_out
);

    logic [NW+1:0] shifted;
    logic          fits;

    always_comb
    begin
        shifted = {rem_in, num_bit};
        fits    = shifted >= {2'b00, den_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= fits ? (NW+1)'(shifted - {2'b00, den_in})
                             : shifted[NW:0];
            den_out  <= den_in;
            quo_out  <= {quo_in[QW-2:0], fits};
            pass_out <= pass_in;
        end
    end

endmodule

/* src/asp_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// asp_sqrt_cell
// one digit-by-digit square root step, two radicand bits per cycle while en is high
// ----------------------------------------------------------------------------
module asp_sqrt_cell #(
    parameter int RW = 32,
    parameter int PW = 128
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW+1:0] rem_in,
    input  logic [RW-1:0] root_in,
    input  logic [1:0]    pair,
    input  logic [PW-1:0] pass_in,
    output logic [RW+1:0] rem_out,
    output logic [RW-1:0] root_out,
    output logic [PW-1:0] pass_out
);

    logic [RW+3:0] trial;
    logic [RW+3:0] cur;

    always_comb
    begin
        cur   = {rem_in, pair};
        trial = (RW+4)'({root_in, 2'b01});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cur >= trial)
            begin
                rem_out  <= (RW+2)'(cur - trial);
                root_out <= {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_out  <= cur[RW+1:0];
                root_out <= {root_in[RW-2:0], 1'b0};
            end
            pass_out <= pass_in;
        end
    end

endmodule

/* src/asp_cordic_cell.sv */
// ----------------------------------------------------------------------------
// asp_cordic_cell
// one rotation-mode cordic micro-rotation with a fixed shift
// ----------------------------------------------------------------------------
module asp_cordic_cell #(
    parameter int STEP = 0,
    parameter int PW   = 128
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [asp_pkg::CD_W-1:0] x_in,
    input  logic signed [asp_pkg::CD_W-1:0] y_in,
    input  logic signed [asp_pkg::CD_W-1:0] z_in,
    input  logic [PW-1:0]                   pass_in,
    output logic signed [asp_pkg::CD_W-1:0] x_out,
    output logic signed [asp_pkg::CD_W-1:0] y_out,
    output logic signed [asp_pkg::CD_W-1:0] z_out,
    output logic [PW-1:0]                   pass_out
);

    logic signed [asp_pkg::CD_W-1:0] dx;
    logic signed [asp_pkg::CD_W-1:0] dy;
    logic signed [asp_pkg::CD_W-1:0] at;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        at = asp_pkg::atan_q30(STEP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (z_in >= 0)
            begin
                x_out <= x_in - dx;
                y_out <= y_in + dy;
                z_out <= z_in - at;
            end
            else
            begin
                x_out <= x_in + dx;
                y_out <= y_in - dy;
                z_out <= z_in + at;
            end
            pass_out <= pass_in;
        end
    end

endmodule

/* src/archimedean_spiral_point_generator.sv */
// ----------------------------------------------------------------------------
// archimedean_spiral_point_generator
// one archimedean spiral point per input word, through a chain of cells
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  s_axis   | in        | tvalid / tready  | start_x, start_y, height_z, point_index
//  m_axis   | out       | tvalid / tready  | point_x, point_y, point_z
//  cfg      | in        | cfg_we           | cfg_index, cfg_data
//
//  one word enters per cycle while the output stage can take a word; it runs through
//  the first quotient register and 30 divider cells, 31 square root cells,
//  4 angle stages, 30 cordic cells, product register and output register
//  the whole chain advances only when the output stage can take a word
//  reset clears valid bits, resets config (count to 100); payload is not reset
// ----------------------------------------------------------------------------
module archimedean_spiral_point_generator #(
    parameter int MAX_POINTS  = 4096,
    parameter int COORD_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, height_z, point_index
    input  logic [((3*COORD_WIDTH+13+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // point_x, point_y, point_z
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int NW   = asp_pkg::IDX_WIDTH;
    localparam int DQ   = 31;          // ratio bits, q1.30 up to 2^30
    localparam int RADW = 62;          // radicand ratio * 2^30
    localparam int RTW  = RADW / 2;    // root bits
    localparam int NS   = asp_pkg::CORDIC_STEPS;
    localparam int PW   = 3 * CW;      // carried sx, sy, z
    localparam int OW   = ((3*CW+7)/8)*8;
    localparam int GW   = CW + 32;     // growth times angle
    localparam int RW   = CW + 8;      // radius width
    localparam logic [NW-1:0] MAXC = NW'(MAX_POINTS > 4096 ? 4096 : MAX_POINTS);
    localparam int LAT  = DQ + RTW + 4 + NS + 1;

    localparam logic [asp_pkg::ANG_W-1:0] TURN1 = asp_pkg::ANG_W'(asp_pkg::TWO_PI_Q24);
    localparam logic [asp_pkg::ANG_W-1:0] TURN2 = asp_pkg::ANG_W'(2 * asp_pkg::TWO_PI_Q24);
    localparam logic [asp_pkg::ANG_W-1:0] TURN3 = asp_pkg::ANG_W'(3 * asp_pkg::TWO_PI_Q24);
    localparam logic [asp_pkg::ANG_W-1:0] TURN4 = asp_pkg::ANG_W'(4 * asp_pkg::TWO_PI_Q24);
    localparam logic [asp_pkg::ANG_W-1:0] TURN5 = asp_pkg::ANG_W'(5 * asp_pkg::TWO_PI_Q24);

    // ------------------------------------------------------------ config
    logic signed [CW-1:0] offset_a_reg;
    logic signed [CW-1:0] growth_b_reg;
    logic [NW-1:0]        point_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_a_reg    <= '0;
            growth_b_reg    <= '0;
            point_count_reg <= asp_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                asp_pkg::REG_OFFSET_A:    offset_a_reg    <= cfg_data;
                asp_pkg::REG_GROWTH_B:    growth_b_reg    <= cfg_data;
                asp_pkg::REG_POINT_COUNT: point_count_reg <= cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ flow
    logic en;
    logic [LAT-1:0] vld_reg;
    logic m_valid_reg;
    logic [OW-1:0] m_data_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    // ------------------------------------------------------------ clamp
    logic [NW-1:0] n_in;
    logic [NW-1:0] cnt_eff;
    logic [NW-1:0] n_eff;
    logic [PW-1:0] pass0;

    always_comb
    begin
        n_in    = s_axis_tdata[3*CW +: NW];
        cnt_eff = (point_count_reg == '0) ? NW'(1) : point_count_reg;
        if (cnt_eff > MAXC)
            cnt_eff = MAXC;
        n_eff = (n_in > cnt_eff) ? cnt_eff : n_in;
        pass0 = s_axis_tdata[PW-1:0];
    end

    // ------------------------------------------------------------ divider
    // numerator n * 2^30, 43 bits; top 12 quotient bits are zero since n <= cnt
    // integer quotient of n / cnt is 0 or 1, settled ahead of the cells
    logic [NW:0]   pre_rem;
    logic          pre_q;
    always_comb
    begin
        pre_q   = (n_eff == cnt_eff);
        pre_rem = pre_q ? '0 : {1'b0, n_eff};
    end

    logic [NW:0]   d0_rem_reg;
    logic [NW-1:0] d0_den_reg;
    logic [DQ-1:0] d0_quo_reg;
    logic [PW-1:0] d0_pas_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_rem_reg <= pre_rem;
            d0_den_reg <= cnt_eff;
            d0_quo_reg <= DQ'(pre_q);
            d0_pas_reg <= pass0;
        end
    end

    logic [NW:0]   dr [0:DQ-1];
    logic [NW-1:0] dd [0:DQ-1];
    logic [DQ-1:0] dq [0:DQ-1];
    logic [PW-1:0] dp [0:DQ-1];

    assign dr[0] = d0_rem_reg;
    assign dd[0] = d0_den_reg;
    assign dq[0] = d0_quo_reg;
    assign dp[0] = d0_pas_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DQ - 1; gi++)
        begin : g_div
            asp_div_cell #(.NW(NW), .QW(DQ), .PW(PW)) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (dr[gi]),
                .den_in  (dd[gi]),
                .num_bit (1'b0),
                .quo_in  (dq[gi]),
                .pass_in (dp[gi]),
                .rem_out (dr[gi+1]),
                .den_out (dd[gi+1]),
                .quo_out (dq[gi+1]),
                .pass_out(dp[gi+1])
            );
        end
    endgenerate

    // the divide uses DQ-1 cells plus the first quotient bit: 30 fraction bits
    logic [DQ-1:0] ratio;
    logic [PW-1:0] pas_div;
    assign ratio   = dq[DQ-1];
    assign pas_div = dp[DQ-1];

    // ------------------------------------------------------------ square root
    logic [RADW-1:0] radicand;
    assign radicand = {1'b0, ratio, 30'd0};

    logic [RTW+1:0]  sr [0:RTW];
    logic [RTW-1:0]  so [0:RTW];
    logic [PW-1:0]   sp [0:RTW];
    logic [RADW-1:0] rad_line [0:RTW];

    assign sr[0]       = '0;
    assign so[0]       = '0;
    assign sp[0]       = pas_div;
    assign rad_line[0] = radicand;

    generate
        for (gi = 0; gi < RTW; gi++)
        begin : g_sqrt
            logic [RADW-1:0] rad_reg;
            always_ff @(posedge clk)
            begin
                if (en)
                    rad_reg <= rad_line[gi];
            end
            assign rad_line[gi+1] = rad_reg;
            asp_sqrt_cell #(.RW(RTW), .PW(PW)) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (sr[gi]),
                .root_in (so[gi]),
                .pair    (rad_line[gi][RADW-1-2*gi -: 2]),
                .pass_in (sp[gi]),
                .rem_out (sr[gi+1]),
                .root_out(so[gi+1]),
                .pass_out(sp[gi+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------ angle
    logic [RTW-1:0] root;
    assign root = so[RTW];

    function automatic logic [27:0] wrap_turn(input logic [asp_pkg::ANG_W-1:0] t);
        logic [asp_pkg::ANG_W-1:0] r;
        if (t >= TURN5)
            r = t - TURN5;
        else if (t >= TURN4)
            r = t - TURN4;
        else if (t >= TURN3)
            r = t - TURN3;
        else if (t >= TURN2)
            r = t - TURN2;
        else if (t >= TURN1)
            r = t - TURN1;
        else
            r = t;
        return r[27:0];
    endfunction

    logic [61:0]          th_prod_reg;
    logic [PW-1:0]        th_pas_reg;
    logic [asp_pkg::ANG_W-1:0] theta_reg;
    logic [PW-1:0]        t2_pas_reg;
    logic [27:0]          phi_mod_reg;
    logic [asp_pkg::ANG_W-1:0] theta2_reg;
    logic [PW-1:0]        t3_pas_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_prod_reg <= 62'(root) * 62'(asp_pkg::TEN_PI_Q24) + 62'(1 << 29);
            th_pas_reg  <= sp[RTW];
            theta_reg   <= th_prod_reg[59:30];
            t2_pas_reg  <= th_pas_reg;
            phi_mod_reg <= wrap_turn(theta_reg);
            theta2_reg  <= theta_reg;
            t3_pas_reg  <= t2_pas_reg;
        end
    end

    // quadrant fold
    logic signed [asp_pkg::CD_W-1:0] z0;
    logic                            neg0;
    always_comb
    begin
        neg0 = 1'b0;
        z0   = asp_pkg::CD_W'($signed({1'b0, phi_mod_reg}));
        if (phi_mod_reg > asp_pkg::HALF_PI_Q24)
        begin
            if (phi_mod_reg < asp_pkg::THREE_HALF_PI_Q24)
            begin
                z0   = z0 - asp_pkg::CD_W'($signed({1'b0, asp_pkg::PI_Q24}));
                neg0 = 1'b1;
            end
            else
                z0 = z0 - asp_pkg::CD_W'($signed({1'b0, asp_pkg::TWO_PI_Q24}));
        end
        z0 = z0 <<< 6;
    end

    // radius, computed alongside the cordic chain
    logic signed [GW-1:0] gt_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            gt_reg <= GW'(growth_b_reg * $signed({1'b0, theta2_reg}));
    end

    // ------------------------------------------------------------ cordic
    localparam int CPW = PW + 1 + RW;
    logic signed [asp_pkg::CD_W-1:0] cx [0:NS];
    logic signed [asp_pkg::CD_W-1:0] cy [0:NS];
    logic signed [asp_pkg::CD_W-1:0] cz [0:NS];
    logic [CPW-1:0]                  cp [0:NS];
    logic [PW-1:0]                   t4_pas_reg;
    logic                            neg_reg;
    logic signed [asp_pkg::CD_W-1:0] z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg      <= z0;
            neg_reg    <= neg0;
            t4_pas_reg <= t3_pas_reg;
        end
    end

    logic signed [RW-1:0] radius;
    assign radius = RW'(offset_a_reg) + RW'((gt_reg + GW'(1 << 23)) >>> 24);

    assign cx[0] = asp_pkg::CORDIC_GAIN_Q30;
    assign cy[0] = '0;
    assign cz[0] = z_reg;
    assign cp[0] = {radius, neg_reg, t4_pas_reg};

    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_cordic
            asp_cordic_cell #(.STEP(gi), .PW(CPW)) u_cell (
                .clk     (clk),
                .en      (en),
                .x_in    (cx[gi]),
                .y_in    (cy[gi]),
                .z_in    (cz[gi]),
                .pass_in (cp[gi]),
                .x_out   (cx[gi+1]),
                .y_out   (cy[gi+1]),
                .z_out   (cz[gi+1]),
                .pass_out(cp[gi+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------ output
    logic signed [asp_pkg::CD_W-1:0] fx;
    logic signed [asp_pkg::CD_W-1:0] fy;
    logic signed [27:0]              c24;
    logic signed [27:0]              s24;
    logic signed [RW-1:0]            r_f;
    logic [PW-1:0]                   p_f;

    always_comb
    begin
        fx  = cp[NS][PW] ? -cx[NS] : cx[NS];
        fy  = cp[NS][PW] ? -cy[NS] : cy[NS];
        c24 = 28'((fx + 34'sd32) >>> 6);
        s24 = 28'((fy + 34'sd32) >>> 6);
        r_f = cp[NS][CPW-1 -: RW];
        p_f = cp[NS][PW-1:0];
    end

    logic signed [RW+27:0] mx_reg;
    logic signed [RW+27:0] my_reg;
    logic [PW-1:0]         po_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= r_f * c24;
            my_reg <= r_f * s24;
            po_reg <= p_f;
        end
    end

    function automatic logic [CW-1:0] sat(input logic signed [RW+28:0] v);
        logic signed [RW+28:0] hi;
        logic signed [RW+28:0] lo;
        hi = (RW+29)'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi)
            return hi[CW-1:0];
        if (v < lo)
            return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    logic signed [RW+28:0] sx_f;
    logic signed [RW+28:0] sy_f;
    always_comb
    begin
        sx_f = (RW+29)'($signed(po_reg[CW-1:0]))
             + (((RW+29)'(mx_reg) + (RW+29)'(1 << 23)) >>> 24);
        sy_f = (RW+29)'($signed(po_reg[2*CW-1:CW]))
             + (((RW+29)'(my_reg) + (RW+29)'(1 << 23)) >>> 24);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= vld_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m_data_reg <= OW'({po_reg[3*CW-1:2*CW], sat(sy_f), sat(sx_f)});
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    logic unused_sig;
    assign unused_sig = ^{sr[RTW], dr[DQ-1], dd[DQ-1], rad_line[RTW], cz[NS]};

    // ------------------------------------------------------------ checks
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        point_count_reg == '0 |-> cnt_eff == NW'(1))
        else $error("zero count not treated as one");

endmodule
